### hw/rtl/pfdrc_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the packet FIFO with duplicate check and range count.
// No dependencies.
package pfdrc_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 16;
  localparam int TS_W   = 30;
  localparam int LIM_W  = 7;
  localparam int CNT_W  = 7;
  localparam int PKT_W  = 2 * ID_W + TS_W;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FWD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CNT = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RST = 7'd64;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_FIN   = 6'b000100,
    ST_FWD   = 6'b001000,
    ST_FWAIT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic commit_add;
    logic fwd_rd;
    logic pop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic             scan_end;
    logic             rd_pend;
    logic             hit;
    logic             empty;
    logic             out_busy;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage

### hw/rtl/pfdrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfdrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pfdrc_ctrl.sv
// Controller state machine: sequences scan, commit, forward and result load.
// Depends on pfdrc_pkg.
module pfdrc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [pfdrc_pkg::CMD_W-1:0] in_cmd,
  output logic                       in_stall,
  input  pfdrc_pkg::dp_stat_t        stat,
  output pfdrc_pkg::dp_cmd_t         cmd
);

  pfdrc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfdrc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != pfdrc_pkg::ST_IDLE);
    case (state_r)
      pfdrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_cmd)
            pfdrc_pkg::CMD_ADD: state_nxt = pfdrc_pkg::ST_SCAN;
            pfdrc_pkg::CMD_CNT: state_nxt = pfdrc_pkg::ST_SCAN;
            pfdrc_pkg::CMD_FWD: state_nxt = pfdrc_pkg::ST_FWD;
            default:            state_nxt = pfdrc_pkg::ST_DONE;
          endcase
        end
      end
      pfdrc_pkg::ST_SCAN: begin
        // keep issuing reads until every live entry is out; wait for the last compare
        cmd.scan_rd = !stat.scan_end;
        if (stat.scan_end && !stat.rd_pend) begin
          state_nxt = pfdrc_pkg::ST_FIN;
        end
      end
      pfdrc_pkg::ST_FIN: begin
        cmd.commit_add = (stat.cmd == pfdrc_pkg::CMD_ADD) && !stat.hit;
        state_nxt      = pfdrc_pkg::ST_DONE;
      end
      pfdrc_pkg::ST_FWD: begin
        if (stat.empty) begin
          state_nxt = pfdrc_pkg::ST_DONE;
        end else begin
          cmd.fwd_rd = 1'b1;
          state_nxt  = pfdrc_pkg::ST_FWAIT;
        end
      end
      pfdrc_pkg::ST_FWAIT: begin
        cmd.pop   = 1'b1;
        state_nxt = pfdrc_pkg::ST_DONE;
      end
      pfdrc_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = pfdrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfdrc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/pfdrc_dp.sv
// Datapath: packet store, ring pointers, scan compare/count, limit register
// and the output word register. Depends on pfdrc_pkg and pfdrc_ram.
module pfdrc_dp #(
  parameter int DEPTH = pfdrc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfdrc_pkg::dp_cmd_t           cmd,
  output pfdrc_pkg::dp_stat_t          stat,
  input  logic [pfdrc_pkg::CMD_W-1:0]  in_cmd,
  input  logic [pfdrc_pkg::ID_W-1:0]   in_src_id,
  input  logic [pfdrc_pkg::ID_W-1:0]   in_dst_id,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_stamp,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_range_start,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_range_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfdrc_pkg::LIM_W-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_packet_valid,
  output logic [pfdrc_pkg::ID_W-1:0]   out_src,
  output logic [pfdrc_pkg::ID_W-1:0]   out_dst,
  output logic [pfdrc_pkg::TS_W-1:0]   out_stamp,
  output logic [pfdrc_pkg::CNT_W-1:0]  out_match_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > pfdrc_pkg::LIM_W) ? OW : pfdrc_pkg::LIM_W;
  localparam int IW = pfdrc_pkg::ID_W;
  localparam int TW = pfdrc_pkg::TS_W;
  localparam int PW = pfdrc_pkg::PKT_W;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [OW-1:0] occ_r, occ_nxt, idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [pfdrc_pkg::LIM_W-1:0] limit_r;
  logic hit_r, hit_nxt, rd_pend_r, fwd_ok_r, fwd_ok_nxt;

  logic [pfdrc_pkg::CMD_W-1:0] cmd_q_r;
  logic [IW-1:0] src_q_r, dst_q_r;
  logic [TW-1:0] stamp_q_r, lo_r, hi_r;

  logic          out_valid_r;
  logic          acc_r, pkt_ok_r;
  logic [IW-1:0] osrc_r, odst_r;
  logic [TW-1:0] ostamp_r;
  logic [pfdrc_pkg::CNT_W-1:0] ocnt_r;

  logic [AW-1:0] head_inc, tail_inc, scan_addr, raddr;
  logic [AW:0]   scan_sum;
  logic [CW-1:0] lim_ext, eff_lim;
  logic          full;
  logic [PW-1:0] q;
  logic [IW-1:0] q_src, q_dst;
  logic [TW-1:0] q_stamp;
  logic          eq_all, in_rng;
  logic          res_pkt;

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // idx stays below occupancy while reads are issued, so it fits AW bits
  assign scan_sum  = {1'b0, head_r} + {1'b0, idx_r[AW-1:0]};
  assign scan_addr = (scan_sum >= (AW+1)'(DEPTH)) ? AW'(scan_sum - (AW+1)'(DEPTH))
                                                  : scan_sum[AW-1:0];
  assign raddr     = cmd.fwd_rd ? head_r : scan_addr;

  // limit of zero acts as one, anything above the store size is clamped
  assign lim_ext = CW'(limit_r);
  assign eff_lim = (lim_ext == '0) ? CW'(1) :
                   (lim_ext > CW'(DEPTH)) ? CW'(DEPTH) : lim_ext;
  assign full    = CW'(occ_r) >= eff_lim;

  pfdrc_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit_add),
    .waddr (tail_r),
    .wdata ({src_q_r, dst_q_r, stamp_q_r}),
    .re    (cmd.scan_rd | cmd.fwd_rd),
    .raddr (raddr),
    .q_r   (q)
  );

  assign q_src   = q[PW-1 -: IW];
  assign q_dst   = q[TW +: IW];
  assign q_stamp = q[TW-1:0];

  assign eq_all = (q_src == src_q_r) && (q_dst == dst_q_r) && (q_stamp == stamp_q_r);
  assign in_rng = (q_dst == dst_q_r) && (q_stamp >= lo_r) && (q_stamp <= hi_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    cnt_nxt    = cnt_r;
    fwd_ok_nxt = fwd_ok_r;
    if (cmd.capture) begin
      idx_nxt    = '0;
      hit_nxt    = 1'b0;
      cnt_nxt    = '0;
      fwd_ok_nxt = 1'b0;
    end
    if (cmd.scan_rd) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (rd_pend_r) begin
      hit_nxt = hit_r | eq_all;
      cnt_nxt = cnt_r + OW'(in_rng);
    end
    if (cmd.commit_add) begin
      tail_nxt = tail_inc;
      if (full) begin
        head_nxt = head_inc;   // evict oldest, occupancy unchanged
      end else begin
        occ_nxt = occ_r + 1'b1;
      end
    end
    if (cmd.pop) begin
      head_nxt   = head_inc;
      occ_nxt    = occ_r - 1'b1;
      fwd_ok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      occ_r     <= '0;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      cnt_r     <= '0;
      fwd_ok_r  <= 1'b0;
      rd_pend_r <= 1'b0;
      limit_r   <= pfdrc_pkg::LIMIT_RST;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      occ_r     <= occ_nxt;
      idx_r     <= idx_nxt;
      hit_r     <= hit_nxt;
      cnt_r     <= cnt_nxt;
      fwd_ok_r  <= fwd_ok_nxt;
      rd_pend_r <= cmd.scan_rd;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q_r   <= in_cmd;
      src_q_r   <= in_src_id;
      dst_q_r   <= in_dst_id;
      stamp_q_r <= in_stamp;
      lo_r      <= in_range_start;
      hi_r      <= in_range_end;
    end
  end

  // output word register
  assign res_pkt = (cmd_q_r == pfdrc_pkg::CMD_FWD) && fwd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      acc_r    <= (cmd_q_r == pfdrc_pkg::CMD_ADD) && !hit_r;
      pkt_ok_r <= res_pkt;
      osrc_r   <= res_pkt ? q_src : '0;
      odst_r   <= res_pkt ? q_dst : '0;
      ostamp_r <= res_pkt ? q_stamp : '0;
      ocnt_r   <= (cmd_q_r == pfdrc_pkg::CMD_CNT) ? pfdrc_pkg::CNT_W'(cnt_r) : '0;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_packet_valid = pkt_ok_r;
  assign out_src          = osrc_r;
  assign out_dst          = odst_r;
  assign out_stamp        = ostamp_r;
  assign out_match_count  = ocnt_r;

  assign stat.scan_end = (idx_r == occ_r);
  assign stat.rd_pend  = rd_pend_r;
  assign stat.hit      = hit_r;
  assign stat.empty    = (occ_r == '0);
  assign stat.out_busy = out_valid_r && out_stall;
  assign stat.cmd      = cmd_q_r;

endmodule

### hw/rtl/packet_fifo_dedup_range_count.sv
// Top level of the packet FIFO with duplicate check and range count.
// Depends on pfdrc_pkg, pfdrc_ctrl, pfdrc_dp (which holds pfdrc_ram).

// One word in, one word out, one word at a time. Add and count walk every
// stored packet through the single read port of the packet store, one per
// cycle. The result sits in an output register, so the input side is free
// again as soon as the word is parked there. Add refuses an exact duplicate
// of a stored packet; otherwise it evicts the oldest packet when the memory
// limit is reached (a limit of zero acts as one, above DEPTH as DEPTH). The
// limit is to be written through the cfg port only while no word is in
// flight; the block itself does not enforce this.
module packet_fifo_dedup_range_count #(
  parameter int DEPTH = pfdrc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pfdrc_pkg::CMD_W-1:0]  in_cmd,
  input  logic [pfdrc_pkg::ID_W-1:0]   in_src_id,
  input  logic [pfdrc_pkg::ID_W-1:0]   in_dst_id,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_stamp,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_range_start,
  input  logic [pfdrc_pkg::TS_W-1:0]   in_range_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic                         out_packet_valid,
  output logic [pfdrc_pkg::ID_W-1:0]   out_src,
  output logic [pfdrc_pkg::ID_W-1:0]   out_dst,
  output logic [pfdrc_pkg::TS_W-1:0]   out_stamp,
  output logic [pfdrc_pkg::CNT_W-1:0]  out_match_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfdrc_pkg::LIM_W-1:0]  cfg_data
);

  pfdrc_pkg::dp_cmd_t  dp_cmd;
  pfdrc_pkg::dp_stat_t dp_stat;

  pfdrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  pfdrc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .in_cmd           (in_cmd),
    .in_src_id        (in_src_id),
    .in_dst_id        (in_dst_id),
    .in_stamp         (in_stamp),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_packet_valid (out_packet_valid),
    .out_src          (out_src),
    .out_dst          (out_dst),
    .out_stamp        (out_stamp),
    .out_match_count  (out_match_count)
  );

endmodule

### hw/rtl/pfdrc_chk.sv
// Port-level checker for packet_fifo_dedup_range_count, bound to the top level.
// Depends on pfdrc_pkg.
module pfdrc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_accepted,
  input logic                         out_packet_valid,
  input logic [pfdrc_pkg::ID_W-1:0]   out_src,
  input logic [pfdrc_pkg::ID_W-1:0]   out_dst,
  input logic [pfdrc_pkg::TS_W-1:0]   out_stamp,
  input logic [pfdrc_pkg::CNT_W-1:0]  out_match_count
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // words taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result word without an outstanding input word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second word taken while one is in progress");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_packet_valid)
                  && !(out_accepted && out_match_count != '0)
                  && !(out_packet_valid && out_match_count != '0))
    else $error("result word mixes fields of different commands");

  a_empty_packet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_valid |-> out_src == '0 && out_dst == '0 && out_stamp == '0)
    else $error("packet fields not zero without a forwarded packet");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_count)
                               && $stable(out_stamp) && $stable(out_accepted))
    else $error("stalled result word changed");

endmodule

bind packet_fifo_dedup_range_count pfdrc_chk u_pfdrc_chk (.*);

### sim/tb_packet_fifo_dedup_range_count.sv
// Self-checking bench for packet_fifo_dedup_range_count: a mirror of the packet store
// predicts every reply (add, forward, count, unknown) and checks the replies in order.
// Depends on pfdrc_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_packet_fifo_dedup_range_count;

  localparam int DEPTH_DEF = pfdrc_pkg::DEPTH_DEF;
  localparam int CMD_W     = pfdrc_pkg::CMD_W;
  localparam int ID_W      = pfdrc_pkg::ID_W;
  localparam int TS_W      = pfdrc_pkg::TS_W;
  localparam int LIM_W     = pfdrc_pkg::LIM_W;
  localparam int CNT_W     = pfdrc_pkg::CNT_W;
  localparam logic [CMD_W-1:0] CMD_ADD   = pfdrc_pkg::CMD_ADD;
  localparam logic [CMD_W-1:0] CMD_FWD   = pfdrc_pkg::CMD_FWD;
  localparam logic [CMD_W-1:0] CMD_CNT   = pfdrc_pkg::CMD_CNT;
  localparam logic [LIM_W-1:0] LIMIT_RST = pfdrc_pkg::LIMIT_RST;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_TAIL  = DEPTH_DEF + 16;
  localparam int CFG_SETTLE  = 8;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 235;
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
  localparam logic [TS_W-1:0]  TS_MAX  = {TS_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_MAX  = {ID_W{1'b1}};

  typedef struct packed {
    logic             accepted;
    logic             pkt_valid;
    logic [ID_W-1:0]  src;
    logic [ID_W-1:0]  dst;
    logic [TS_W-1:0]  ts;
    logic [CNT_W-1:0] hits;
  } reply_t;

  // Mirror of the packet store; predicts one reply per accepted word.
  class packet_mirror;
    logic [ID_W-1:0]  src_mem [DEPTH_DEF];
    logic [ID_W-1:0]  dst_mem [DEPTH_DEF];
    logic [TS_W-1:0]  ts_mem  [DEPTH_DEF];
    int head, tail, occ;
    logic [LIM_W-1:0] limit;
    reply_t reply_q[$];
    int errors;
    int n_stored, n_refused, n_evicted, n_popped, n_empty, n_hits, n_unknown, peak;

    function new();
      limit = LIMIT_RST;
    endfunction

    function void drop_oldest();
      if (occ == 0) return;
      head = (head + 1) % DEPTH_DEF;
      occ--;
    endfunction

    function void take_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] s, logic [ID_W-1:0] d,
                           logic [TS_W-1:0] t, logic [TS_W-1:0] lo, logic [TS_W-1:0] hi);
      reply_t r;
      int k, p, lim, n;
      bit dup;
      r = '0;
      dup = 0;
      n = 0;
      case (cmd)
        CMD_ADD: begin
          for (k = 0; k < occ; k++) begin
            p = (head + k) % DEPTH_DEF;
            if (src_mem[p] == s && dst_mem[p] == d && ts_mem[p] == t) dup = 1;
          end
          if (dup) begin
            n_refused++;
          end else begin
            lim = (limit == 0) ? 1 : int'(limit);
            if (lim > DEPTH_DEF) lim = DEPTH_DEF;
            // one eviction per add, even with the limit lowered below occupancy
            if (occ >= lim) begin
              drop_oldest();
              n_evicted++;
            end
            if (occ >= DEPTH_DEF) drop_oldest();
            src_mem[tail] = s;
            dst_mem[tail] = d;
            ts_mem[tail]  = t;
            tail = (tail + 1) % DEPTH_DEF;
            occ++;
            if (occ > peak) peak = occ;
            r.accepted = 1'b1;
            n_stored++;
          end
        end
        CMD_FWD: begin
          if (occ != 0) begin
            r.pkt_valid = 1'b1;
            r.src = src_mem[head];
            r.dst = dst_mem[head];
            r.ts  = ts_mem[head];
            drop_oldest();
            n_popped++;
          end else begin
            n_empty++;
          end
        end
        CMD_CNT: begin
          for (k = 0; k < occ; k++) begin
            p = (head + k) % DEPTH_DEF;
            if (dst_mem[p] == d && ts_mem[p] >= lo && ts_mem[p] <= hi) n++;
          end
          r.hits = n[CNT_W-1:0];
          if (n != 0) n_hits++;
        end
        default: n_unknown++;
      endcase
      reply_q = {reply_q, r};
    endfunction

    function void match_reply(reply_t got);
      reply_t want;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: reply with nothing outstanding: %p", $time, got);
        return;
      end
      want = reply_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: reply mismatch (exp/got) acc %b/%b pkt %b/%b src %h/%h", $time,
                   want.accepted, got.accepted, want.pkt_valid, got.pkt_valid,
                   want.src, got.src);
          $display("  dst %h/%h ts %h/%h cnt %0d/%0d",
                   want.dst, got.dst, want.ts, got.ts, want.hits, got.hits);
        end
      end
    endfunction

    function void settle();
      if (reply_q.size() != 0) begin
        errors += reply_q.size();
        $display("%0t: %0d replies never arrived", $time, reply_q.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd = '0;
  logic [ID_W-1:0]    in_src_id = '0;
  logic [ID_W-1:0]    in_dst_id = '0;
  logic [TS_W-1:0]    in_stamp = '0;
  logic [TS_W-1:0]    in_range_start = '0;
  logic [TS_W-1:0]    in_range_end = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic               out_packet_valid;
  logic [ID_W-1:0]    out_src;
  logic [ID_W-1:0]    out_dst;
  logic [TS_W-1:0]    out_stamp;
  logic [CNT_W-1:0]   out_match_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIM_W-1:0]   cfg_data = '0;

  packet_mirror board;
  int burst_left = 0;
  int n_words = 0;
  int n_cfg = 0;
  int cycle_cnt = 0;
  logic [TS_W-1:0] stamp_now = '0;
  logic [ID_W-1:0] src_pool [4];
  logic [ID_W-1:0] dst_pool [4];
  logic [ID_W-1:0] rec_src [8];
  logic [ID_W-1:0] rec_dst [8];
  logic [TS_W-1:0] rec_ts [8];
  int rec_wr = 0;
  logic [1:0] stall_mode = '0;
  logic [15:0] stall_tick = '0;

  packet_fifo_dedup_range_count u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_src_id        (in_src_id),
    .in_dst_id        (in_dst_id),
    .in_stamp         (in_stamp),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_packet_valid (out_packet_valid),
    .out_src          (out_src),
    .out_dst          (out_dst),
    .out_stamp        (out_stamp),
    .out_match_count  (out_match_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: checks every accepted reply; a new stall mode is drawn when the low nine bits of stall_tick are zero.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_reply({out_accepted, out_packet_valid, out_src, out_dst, out_stamp,
                         out_match_count});
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[8:0] == 9'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_tick[3:0] < 4'd5);
    endcase
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_packet_fifo_dedup_range_count: done, errors");
    $finish;
  end

  // Drives one word, with a random gap when a new burst starts.
  task automatic send_word(logic [CMD_W-1:0] c, logic [ID_W-1:0] s, logic [ID_W-1:0] d,
                           logic [TS_W-1:0] t, logic [TS_W-1:0] lo, logic [TS_W-1:0] hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd         <= c;
    in_src_id      <= s;
    in_dst_id      <= d;
    in_stamp       <= t;
    in_range_start <= lo;
    in_range_end   <= hi;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.take_cmd(c, s, d, t, lo, hi);
    burst_left--;
    n_words++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (board.reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIM_W-1:0] v);
    go_quiet();
    wait_drain();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.limit = v;
    n_cfg++;
  endtask

  task automatic random_word(int fwd_pct, bit one_dst);
    int sel, slot;
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0] s, d;
    logic [TS_W-1:0] t, lo, hi;
    sel = $urandom_range(0, 99);
    s = src_pool[$urandom_range(0, 3)];
    d = one_dst ? dst_pool[0] : dst_pool[$urandom_range(0, 3)];
    // mostly rising stamps, now and then a jump anywhere
    if ($urandom_range(0, 39) == 0) stamp_now = TS_W'($urandom);
    else stamp_now = stamp_now + TS_W'($urandom_range(0, 2));
    t  = stamp_now;
    lo = TS_W'($urandom);
    hi = TS_W'($urandom);
    if (sel < 6) begin
      c = CMD_W'($urandom);
      s = ID_W'($urandom);
      d = ID_W'($urandom);
      t = TS_W'($urandom);
    end else if (sel < 6 + fwd_pct) begin
      c = CMD_FWD;
    end else if (sel < 31 + fwd_pct) begin
      c = CMD_CNT;
      case ($urandom_range(0, 5))
        0: begin lo = '0; hi = TS_MAX; end
        1: begin lo = t; hi = t - TS_W'($urandom_range(1, 20)); end
        2: begin lo = t; hi = t; end
        default: begin
          lo = t - TS_W'($urandom_range(0, 40));
          hi = lo + TS_W'($urandom_range(0, 50));
        end
      endcase
    end else begin
      c = CMD_ADD;
      if ($urandom_range(0, 5) == 0) begin
        slot = $urandom_range(0, 7);
        s = rec_src[slot];
        d = rec_dst[slot];
        t = rec_ts[slot];
      end else begin
        rec_src[rec_wr] = s;
        rec_dst[rec_wr] = d;
        rec_ts[rec_wr]  = t;
        rec_wr = (rec_wr + 1) % 8;
      end
    end
    send_word(c, s, d, t, lo, hi);
  endtask

  task automatic directed_words();
    int i;
    send_word(CMD_FWD, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);   // forward while empty
    send_word(CMD_CNT, '0, '0, '0, '0, TS_MAX);
    send_word(CMD_BAD, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_word(CMD_ADD, '0, '0, '0, TS_MAX, TS_MAX);
    send_word(CMD_ADD, ID_MAX, ID_MAX, TS_MAX, '0, '0);
    send_word(CMD_ADD, '0, '0, '0, '0, '0);                     // exact duplicate
    send_word(CMD_ADD, '0, '0, TS_W'(1), '0, '0);
    send_word(CMD_ADD, ID_W'(1), '0, '0, '0, '0);
    send_word(CMD_ADD, '0, ID_W'(1), '0, '0, '0);
    send_word(CMD_CNT, '0, '0, '0, '0, TS_MAX);
    send_word(CMD_CNT, '0, '0, '0, TS_W'(1), TS_W'(1));
    send_word(CMD_CNT, '0, '0, '0, TS_W'(1), '0);               // start above end
    send_word(CMD_CNT, '0, ID_MAX, '0, TS_MAX, TS_MAX);
    send_word(CMD_BAD, '0, '0, TS_W'(2), '0, '0);
    send_word(CMD_FWD, '0, '0, '0, '0, '0);
    send_word(CMD_ADD, '0, '0, '0, '0, '0);                     // gone, so stored again
    for (i = 0; i < 10; i++)
      send_word(CMD_ADD, ID_W'(i + 2), 16'h55aa, TS_W'(100 + i), '0, '0);
    // limit lowered under the occupancy: adds evict one each
    set_limit(LIM_W'(3));
    send_word(CMD_ADD, 16'h1234, 16'h55aa, TS_W'(200), '0, '0);
    send_word(CMD_ADD, 16'h1235, 16'h55aa, TS_W'(201), '0, '0);
    send_word(CMD_CNT, '0, 16'h55aa, '0, '0, TS_MAX);
    send_word(CMD_FWD, '0, '0, '0, '0, '0);
  endtask

  initial begin : stimulus
    int ph, w;
    logic [LIM_W-1:0] phase_lim [N_PHASES];
    int fwd_pct [N_PHASES];
    phase_lim = '{7'd64, 7'd0, 7'd127, 7'd7, 7'd1, 7'd64, 7'd100, 7'd2};
    fwd_pct   = '{8, 20, 10, 25, 30, 6, 12, 20};
    board = new();
    src_pool = '{16'h0000, ID_MAX, ID_W'($urandom), ID_W'($urandom)};
    dst_pool = '{16'h0000, ID_MAX, ID_W'($urandom), ID_W'($urandom)};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (ph = 0; ph < N_PHASES; ph++) begin
      set_limit((ph == N_PHASES - 1) ? LIM_W'($urandom_range(2, 63)) : phase_lim[ph]);
      if (ph == 3) stamp_now = TS_MAX - TS_W'(100);   // let stamps run over the top
      for (w = 0; w < PHASE_WORDS; w++) begin
        random_word(fwd_pct[ph], ph == 5);
        if ($urandom_range(0, 59) == 0) begin
          go_quiet();
          wait_drain();
        end
      end
    end
    go_quiet();
    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    board.settle();
    $display("summary: %0d words, %0d limit writes; %0d stored, %0d refused, %0d evicted",
             n_words, n_cfg, board.n_stored, board.n_refused, board.n_evicted);
    $display("summary: %0d forwarded, %0d on empty, %0d counts with hits, %0d unknown, peak %0d",
             board.n_popped, board.n_empty, board.n_hits, board.n_unknown, board.peak);
    if (board.errors == 0)
      $display("tb_packet_fifo_dedup_range_count: done, clean");
    else
      $display("tb_packet_fifo_dedup_range_count: done, errors");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pfdrc_pkg.sv
hw/rtl/pfdrc_ram.sv
hw/rtl/pfdrc_ctrl.sv
hw/rtl/pfdrc_dp.sv
hw/rtl/packet_fifo_dedup_range_count.sv
hw/rtl/pfdrc_chk.sv
sim/tb_packet_fifo_dedup_range_count.sv
